// ===== rtl/wma_pkg.sv =====
// Package for the windowed moving average: widths, limits, cell and status types.
`default_nettype none
package wma_pkg;

    localparam int MAX_WINDOW = 256;
    localparam int IDX_W      = $clog2(MAX_WINDOW);
    localparam int LEN_W      = 9;
    localparam int SAMPLE_W   = 32;
    localparam int SUM_W      = 41;
    localparam int AVG_W      = 31;
    localparam int CNT_W      = $clog2(SUM_W + 1);
    localparam int TDATA_W    = ((AVG_W + 2 * SAMPLE_W + 7) / 8) * 8;

    localparam logic [LEN_W-1:0]           LEN_RESET = LEN_W'(16);
    localparam logic [LEN_W-1:0]           MAX_LEN   = LEN_W'(MAX_WINDOW);
    localparam logic [IDX_W-1:0]           LAST_IDX  = IDX_W'(MAX_WINDOW - 1);
    localparam logic [SUM_W-1:0]           SUM_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [AVG_W-1:0]           AVG_MAX   = {AVG_W{1'b1}};
    localparam logic signed [SAMPLE_W-1:0] MINUS_ONE = -SAMPLE_W'(65536);

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef struct packed {
        logic                       valid;
        logic signed [SAMPLE_W-1:0] data;
    } t_entry;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRAP,
        ST_SCAN,
        ST_SUM,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/wma_cell.sv =====
// One slot of the rotating window store: holds an entry and passes it on each shift.
`default_nettype none
module wma_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_clear,
    input  wire logic            i_shift,
    input  wire wma_pkg::t_entry i_entry,
    output wma_pkg::t_entry      o_entry
);

    logic                               r_valid;
    logic signed [wma_pkg::SAMPLE_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= i_entry.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_entry.data;
        end
    end

    // an entry never written reads as zero
    assign o_entry.valid = r_valid;
    assign o_entry.data  = r_valid ? r_data : '0;

endmodule
`default_nettype wire

// ===== rtl/wma_divider.sv =====
// Restoring divider, one quotient bit per cycle, with quotient and remainder.
`default_nettype none
module wma_divider (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [wma_pkg::SUM_W-1:0]  i_dividend,
    input  wire logic [wma_pkg::LEN_W-1:0]  i_divisor,
    output wma_pkg::t_div_stat              o_stat,
    output logic      [wma_pkg::SUM_W-1:0]  o_quot,
    output logic      [wma_pkg::LEN_W-1:0]  o_rem
);

    logic                        r_busy;
    logic                        r_done;
    logic [wma_pkg::CNT_W-1:0]   r_cnt;
    logic [wma_pkg::SUM_W-1:0]   r_quo;
    logic [wma_pkg::LEN_W-1:0]   r_rem;
    logic [wma_pkg::LEN_W-1:0]   r_den;
    logic [wma_pkg::LEN_W:0]     w_trial;
    logic [wma_pkg::LEN_W:0]     w_diff;
    logic                        w_ge;

    assign w_trial = {r_rem, r_quo[wma_pkg::SUM_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= wma_pkg::CNT_W'(wma_pkg::SUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - wma_pkg::CNT_W'(1);
                if (r_cnt == wma_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_den <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[wma_pkg::SUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[wma_pkg::LEN_W-1:0] : w_trial[wma_pkg::LEN_W-1:0];
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quo;
    assign o_rem       = r_rem;

endmodule
`default_nettype wire

// ===== rtl/windowed_moving_average_top.sv =====
// Top level of the windowed moving average: controller, cell ring, divider, output register.
// Each item makes one ring revolution, a sum update and a 41-step divide before its result is valid;
//   clear and non-positive sums skip the divide.
// A write position that falls beyond a shortened window costs a further 41-step divide first.
// A new item is taken only in the idle state, after the last result has gone into the output register.
// Reset (synchronous, active low) empties all cells, zeroes sum and average, sets length 16.
`default_nettype none
module windowed_moving_average_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration: window_length
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [wma_pkg::LEN_W-1:0]     i_cfg_data,
    // input items
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [wma_pkg::SAMPLE_W-1:0]  s_axis_tdata,  // sample
    input  wire logic                          s_axis_tuser,  // command
    // result items
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [wma_pkg::TDATA_W-1:0]        m_axis_tdata,  // average, latest, highest, pad
    output logic                               m_axis_tlast   // at_last_slot
);

    wma_pkg::t_state r_state;
    wma_pkg::t_state n_state;

    logic [wma_pkg::LEN_W-1:0]             r_wlen;
    logic [wma_pkg::LEN_W-1:0]             w_len;
    logic [wma_pkg::IDX_W-1:0]             r_pos;
    logic [wma_pkg::IDX_W-1:0]             r_idx;
    logic                                  r_empty;
    logic                                  r_filled;
    logic [wma_pkg::SUM_W-1:0]             r_sum;
    logic [wma_pkg::AVG_W-1:0]             r_avg;
    logic                                  r_cmd;
    logic signed [wma_pkg::SAMPLE_W-1:0]   r_sample;
    logic signed [wma_pkg::SAMPLE_W-1:0]   r_old;
    logic signed [wma_pkg::SAMPLE_W-1:0]   r_latest;
    logic signed [wma_pkg::SAMPLE_W-1:0]   r_hi;

    logic                                  r_out_valid;
    logic [wma_pkg::AVG_W-1:0]             r_out_avg;
    logic [wma_pkg::SAMPLE_W-1:0]          r_out_latest;
    logic [wma_pkg::SAMPLE_W-1:0]          r_out_hi;
    logic                                  r_out_last;

    logic                                  w_accept;
    logic                                  w_load;
    logic [wma_pkg::LEN_W-1:0]             w_next_pos;
    logic                                  w_need_wrap;

    logic                                  w_div_start;
    logic [wma_pkg::SUM_W-1:0]             w_div_a;
    logic [wma_pkg::LEN_W-1:0]             w_div_b;
    wma_pkg::t_div_stat                    w_div;
    logic [wma_pkg::SUM_W-1:0]             w_quot;
    logic [wma_pkg::LEN_W-1:0]             w_rem;

    wma_pkg::t_entry                       w_cell [wma_pkg::MAX_WINDOW];
    wma_pkg::t_entry                       w_ring_in;
    logic                                  w_shift;
    logic                                  w_clear;
    logic                                  w_hit;
    logic signed [wma_pkg::SAMPLE_W-1:0]   w_cur;

    logic signed [wma_pkg::SUM_W:0]        w_sum;
    logic                                  w_sum_pos;
    logic                                  w_filled_n;
    logic [wma_pkg::LEN_W-1:0]             w_divisor;

    // window length saturated into 1..MAX_WINDOW
    always_comb begin
        if (r_wlen == '0) begin
            w_len = wma_pkg::LEN_W'(1);
        end else if (r_wlen > wma_pkg::MAX_LEN) begin
            w_len = wma_pkg::MAX_LEN;
        end else begin
            w_len = r_wlen;
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == wma_pkg::ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_load        = (r_state == wma_pkg::ST_DONE) && (!r_out_valid || m_axis_tready);

    assign w_next_pos  = wma_pkg::LEN_W'(r_pos) + wma_pkg::LEN_W'(1);
    assign w_need_wrap = !r_empty && (w_next_pos > w_len);

    // ring of cells: cell 0 is the head, the head entry re-enters at the tail
    assign w_shift = (r_state == wma_pkg::ST_SCAN);
    assign w_clear = w_accept && (s_axis_tuser == wma_pkg::CMD_CLEAR);
    assign w_hit   = (r_cmd == wma_pkg::CMD_ADD) && (r_idx == r_pos);

    always_comb begin
        if (w_hit) begin
            w_ring_in.valid = 1'b1;
            w_ring_in.data  = r_sample;
        end else begin
            w_ring_in = w_cell[0];
        end
        w_cur = w_ring_in.data;
    end

    for (genvar k = 0; k < wma_pkg::MAX_WINDOW; k++) begin : g_cell
        wma_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clear (w_clear),
            .i_shift (w_shift),
            .i_entry ((k == wma_pkg::MAX_WINDOW - 1) ? w_ring_in : w_cell[(k + 1) % wma_pkg::MAX_WINDOW]),
            .o_entry (w_cell[k])
        );
    end

    // sum update and divisor
    assign w_sum = $signed({1'b0, r_sum})
                 - $signed({{(wma_pkg::SUM_W + 1 - wma_pkg::SAMPLE_W){r_old[wma_pkg::SAMPLE_W-1]}},
                            r_old})
                 + $signed({{(wma_pkg::SUM_W + 1 - wma_pkg::SAMPLE_W){r_sample[wma_pkg::SAMPLE_W-1]}},
                            r_sample});
    assign w_sum_pos  = !w_sum[wma_pkg::SUM_W] && (w_sum != '0);
    assign w_filled_n = r_filled || (wma_pkg::LEN_W'(r_pos) == w_len - wma_pkg::LEN_W'(1));
    assign w_divisor  = w_filled_n ? w_len : wma_pkg::LEN_W'(r_pos) + wma_pkg::LEN_W'(1);

    wma_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_a),
        .i_divisor  (w_div_b),
        .o_stat     (w_div),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wma_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        w_div_start = 1'b0;
        w_div_a     = wma_pkg::SUM_W'(w_next_pos);
        w_div_b     = w_len;
        unique case (r_state)
            wma_pkg::ST_IDLE: begin
                if (w_accept) begin
                    if (s_axis_tuser == wma_pkg::CMD_ADD && w_need_wrap) begin
                        w_div_start = 1'b1;
                        n_state     = wma_pkg::ST_WRAP;
                    end else begin
                        n_state = wma_pkg::ST_SCAN;
                    end
                end
            end
            wma_pkg::ST_WRAP: begin
                if (w_div.done) begin
                    n_state = wma_pkg::ST_SCAN;
                end
            end
            wma_pkg::ST_SCAN: begin
                if (r_idx == wma_pkg::LAST_IDX) begin
                    n_state = wma_pkg::ST_SUM;
                end
            end
            wma_pkg::ST_SUM: begin
                w_div_a = w_sum[wma_pkg::SUM_W-1:0];
                w_div_b = w_divisor;
                if (r_cmd == wma_pkg::CMD_ADD && w_sum_pos) begin
                    w_div_start = 1'b1;
                    n_state     = wma_pkg::ST_DIV;
                end else begin
                    n_state = wma_pkg::ST_DONE;
                end
            end
            wma_pkg::ST_DIV: begin
                if (w_div.done) begin
                    n_state = wma_pkg::ST_DONE;
                end
            end
            wma_pkg::ST_DONE: begin
                if (w_load) begin
                    n_state = wma_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = wma_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen   <= wma_pkg::LEN_RESET;
            r_pos    <= '0;
            r_idx    <= '0;
            r_empty  <= 1'b1;
            r_filled <= 1'b0;
            r_sum    <= '0;
            r_avg    <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_wlen <= i_cfg_data;
            end
            if (w_accept) begin
                r_idx <= '0;
                if (s_axis_tuser == wma_pkg::CMD_CLEAR) begin
                    r_pos   <= '0;
                    r_empty <= 1'b1;
                    r_sum   <= '0;
                    r_avg   <= '0;
                end else begin
                    r_empty <= 1'b0;
                    if (r_empty || w_next_pos == w_len) begin
                        r_pos <= '0;
                    end else if (!w_need_wrap) begin
                        r_pos <= w_next_pos[wma_pkg::IDX_W-1:0];
                    end
                end
            end
            if (r_state == wma_pkg::ST_WRAP && w_div.done) begin
                r_pos <= w_rem[wma_pkg::IDX_W-1:0];
            end
            if (r_state == wma_pkg::ST_SCAN) begin
                r_idx <= r_idx + wma_pkg::IDX_W'(1);
            end
            if (r_state == wma_pkg::ST_SUM && r_cmd == wma_pkg::CMD_ADD) begin
                r_filled <= w_filled_n;
                if (!w_sum_pos) begin
                    r_sum <= '0;
                    r_avg <= '0;
                end else begin
                    r_sum <= w_sum[wma_pkg::SUM_W-1] ? wma_pkg::SUM_MAX
                                                     : w_sum[wma_pkg::SUM_W-1:0];
                end
            end
            if (r_state == wma_pkg::ST_DIV && w_div.done) begin
                r_avg <= (|w_quot[wma_pkg::SUM_W-1:wma_pkg::AVG_W]) ? wma_pkg::AVG_MAX
                                                                    : w_quot[wma_pkg::AVG_W-1:0];
            end
        end
    end

    // item payload and scan results
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd    <= s_axis_tuser;
            r_sample <= s_axis_tdata;
            r_old    <= '0;
            r_hi     <= wma_pkg::MINUS_ONE;
        end
        if (r_state == wma_pkg::ST_SCAN) begin
            if (r_idx == r_pos) begin
                r_latest <= w_cur;
                r_old    <= w_cell[0].data;
            end
            if (wma_pkg::LEN_W'(r_idx) < w_len && w_cur > r_hi) begin
                r_hi <= w_cur;
            end
        end
    end

    // output register: holds a finished result while the next item is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_avg    <= r_avg;
            r_out_latest <= r_latest;
            r_out_hi     <= r_hi;
            r_out_last   <= !r_empty && (wma_pkg::LEN_W'(r_pos) == w_len - wma_pkg::LEN_W'(1));
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = wma_pkg::TDATA_W'({r_out_hi, r_out_latest, r_out_avg});
    assign m_axis_tlast  = r_out_last;

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != wma_pkg::ST_IDLE))
        else $error("accepted item did not start work");

    a_scan_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wma_pkg::ST_SCAN && r_idx == wma_pkg::LAST_IDX) |=>
        (r_state == wma_pkg::ST_SUM))
        else $error("ring revolution did not end after the last cell");

    a_div_done_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> (r_state == wma_pkg::ST_WRAP || r_state == wma_pkg::ST_DIV))
        else $error("divider finished outside a divide state");

    a_div_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wma_pkg::ST_DIV) |-> (w_div.busy || w_div.done))
        else $error("waiting on an idle divider");

    a_empty_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_empty |-> (r_pos == '0))
        else $error("empty store with nonzero write position");

endmodule
`default_nettype wire

// ===== test/average_checker.sv =====
// Checker for the windowed moving average: predicts every result and compares it on the output.
module average_checker (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_valid,
    input  wire logic                         i_cfg_ready,
    input  wire logic [wma_pkg::LEN_W-1:0]    i_cfg_data,
    input  wire logic                         i_in_valid,
    input  wire logic                         i_in_ready,
    input  wire logic [wma_pkg::SAMPLE_W-1:0] i_in_sample,   // sample
    input  wire logic                         i_in_command,  // command
    input  wire logic                         i_out_valid,
    input  wire logic                         i_out_ready,
    input  wire logic [wma_pkg::TDATA_W-1:0]  i_out_data,    // average, latest, highest, pad
    input  wire logic                         i_out_last,    // at_last_slot
    output int unsigned                       o_outstanding,
    output int unsigned                       o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [wma_pkg::AVG_W-1:0]           average;
        logic signed [wma_pkg::SAMPLE_W-1:0] latest;
        logic signed [wma_pkg::SAMPLE_W-1:0] highest;
        logic                                at_last_slot;
    } avg_result_t;

    longint                    ring [wma_pkg::MAX_WINDOW];
    longint                    window_sum;
    longint                    mean_now;
    int unsigned               write_slot;
    bit                        ring_empty;
    bit                        ring_filled;
    logic [wma_pkg::LEN_W-1:0] length_reg;
    avg_result_t               awaited_results [$];
    int unsigned               result_count = 0;
    int unsigned               mismatches = 0;
    int unsigned               queued = 0;

    assign o_outstanding = queued;
    assign o_errors      = mismatches;

    // Length register saturated into 1..MAX_WINDOW.
    function automatic int unsigned window_span();
        if (length_reg == '0)
            return 1;
        if (length_reg > wma_pkg::MAX_LEN)
            return wma_pkg::MAX_WINDOW;
        return length_reg;
    endfunction

    function automatic void empty_ring();
        foreach (ring[i])
            ring[i] = 0;
        window_sum = 0;
        mean_now   = 0;
        write_slot = 0;
        ring_empty = 1'b1;
    endfunction

    function automatic avg_result_t next_average(input logic command,
                                                 input logic signed [wma_pkg::SAMPLE_W-1:0] sample);
        int unsigned span;
        longint      total;
        longint      quotient;
        longint      peak;
        avg_result_t res;
        span = window_span();
        if (command == wma_pkg::CMD_CLEAR) begin
            empty_ring();
        end else begin
            // first add after empty lands on slot 0, otherwise advance and wrap
            write_slot = ring_empty ? 0 : (write_slot + 1) % span;
            ring_empty = 1'b0;
            total = window_sum - ring[write_slot] + longint'(sample);
            ring[write_slot] = longint'(sample);
            if (write_slot == span - 1)
                ring_filled = 1'b1;
            quotient = total / (ring_filled ? longint'(span) : longint'(write_slot + 1));
            if (total < 0)
                total = 0;
            if (total > longint'(wma_pkg::SUM_MAX))
                total = longint'(wma_pkg::SUM_MAX);
            if (quotient < 0)
                quotient = 0;
            if (quotient > longint'(wma_pkg::AVG_MAX))
                quotient = longint'(wma_pkg::AVG_MAX);
            window_sum = total;
            mean_now   = quotient;
        end
        peak = longint'(wma_pkg::MINUS_ONE);
        for (int i = 0; i < int'(span); i++)
            if (ring[i] > peak)
                peak = ring[i];
        res.average      = mean_now[wma_pkg::AVG_W-1:0];
        res.latest       = ring_empty ? '0 : ring[write_slot][wma_pkg::SAMPLE_W-1:0];
        res.highest      = peak[wma_pkg::SAMPLE_W-1:0];
        res.at_last_slot = !ring_empty && (write_slot == span - 1);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatches < 40)
            $display("%0t: result %0d: %s got %0h want %0h", $realtime, result_count, what,
                     got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        avg_result_t got;
        avg_result_t want;
        if (!i_rst_n) begin
            empty_ring();
            ring_filled = 1'b0;
            length_reg  = wma_pkg::LEN_RESET;
            awaited_results.delete();
        end else begin
            // take the result first: it always belongs to an earlier item
            if (i_out_valid && i_out_ready) begin
                got.average      = i_out_data[wma_pkg::AVG_W-1:0];
                got.latest       = i_out_data[wma_pkg::AVG_W +: wma_pkg::SAMPLE_W];
                got.highest      = i_out_data[wma_pkg::AVG_W + wma_pkg::SAMPLE_W +: wma_pkg::SAMPLE_W];
                got.at_last_slot = i_out_last;
                result_count++;
                if (awaited_results.size() == 0) begin
                    report_mismatch("result with none awaited, average", longint'(got.average), 0);
                end else begin
                    want = awaited_results.pop_front();
                    if (got.average != want.average)
                        report_mismatch("average", longint'(got.average), longint'(want.average));
                    if (got.latest != want.latest)
                        report_mismatch("latest", longint'(got.latest), longint'(want.latest));
                    if (got.highest != want.highest)
                        report_mismatch("highest", longint'(got.highest), longint'(want.highest));
                    if (got.at_last_slot != want.at_last_slot)
                        report_mismatch("at_last_slot", longint'(got.at_last_slot),
                                        longint'(want.at_last_slot));
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                length_reg = i_cfg_data;
            if (i_in_valid && i_in_ready)
                awaited_results.push_back(next_average(i_in_command, i_in_sample));
        end
        queued <= awaited_results.size();
    end

endmodule

// ===== test/testbench.sv =====
// Top of the windowed moving average testbench: clock, reset, stimulus and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ITEM_TARGET = 1750;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_cfg_valid;
    logic                         o_cfg_ready;
    logic [wma_pkg::LEN_W-1:0]    i_cfg_data;
    logic                         s_axis_tvalid;
    logic                         s_axis_tready;
    logic [wma_pkg::SAMPLE_W-1:0] s_axis_tdata;   // sample
    logic                         s_axis_tuser;   // command
    logic                         m_axis_tvalid;
    logic                         m_axis_tready;
    logic [wma_pkg::TDATA_W-1:0]  m_axis_tdata;   // average, latest, highest, pad
    logic                         m_axis_tlast;   // at_last_slot
    int unsigned                  outstanding;
    int unsigned                  errors;
    int unsigned                  burst_left = 0;
    int unsigned                  items_sent = 0;

    windowed_moving_average_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    average_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (s_axis_tvalid),
        .i_in_ready    (s_axis_tready),
        .i_in_sample   (s_axis_tdata),
        .i_in_command  (s_axis_tuser),
        .i_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .i_out_data    (m_axis_tdata),
        .i_out_last    (m_axis_tlast),
        .o_outstanding (outstanding),
        .o_errors      (errors)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #40ms;
        $display("testbench: errors");
        $finish;
    end

    // Result side stalls on a rotating 16-bit mask; about one renewed mask in four is all ones (no stall).
    initial begin
        logic [15:0] stall_mask;
        int unsigned tick;
        m_axis_tready <= 1'b0;
        stall_mask = '1;
        tick = 0;
        forever begin
            @(posedge i_clk);
            if (tick % 64 == 0)
                stall_mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
            m_axis_tready <= stall_mask[tick % 16];
            tick++;
        end
    end

    function automatic logic [wma_pkg::SAMPLE_W-1:0] pick_sample();
        logic [wma_pkg::SAMPLE_W-1:0] corners [7] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
            32'hFFFF_FFFF, 32'hFFFF_0000, 32'hFFFE_FFFF, 32'h0001_0000};
        case ($urandom_range(0, 9))
            0:       return corners[$urandom_range(0, 6)];
            1, 2:    return $urandom;
            3, 4, 5: return $urandom_range(0, 32'h00FF_FFFF);
            6, 7:    return 32'($urandom_range(0, 32'h003F_FFFF)) - 32'h0020_0000;
            default: return 32'h8000_0000 | $urandom;
        endcase
    endfunction

    // Send one item; a new burst starts after a random gap.
    task automatic push_item(input logic command, input logic [wma_pkg::SAMPLE_W-1:0] sample);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 8);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 400) : $urandom_range(0, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sample;
        s_axis_tuser  <= command;
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        items_sent++;
    endtask

    // Write the window length once every awaited result has come back.
    task automatic write_length(input logic [wma_pkg::LEN_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [wma_pkg::LEN_W-1:0] lengths [14] = '{9'd1, 9'd2, 9'd3, 9'd4, 9'd5, 9'd8, 9'd16,
            9'd17, 9'd31, 9'd64, 9'd255, 9'd256, 9'd0, 9'd511};
        logic [wma_pkg::LEN_W-1:0] next_length;
        int unsigned               phase_items;

        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= wma_pkg::CMD_ADD;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset length 16, window not yet filled: divide by the count written so far
        push_item(wma_pkg::CMD_CLEAR, '0);
        push_item(wma_pkg::CMD_ADD, 32'h7FFF_FFFF);
        push_item(wma_pkg::CMD_ADD, 32'h8000_0000);
        push_item(wma_pkg::CMD_ADD, 32'h0000_0000);
        push_item(wma_pkg::CMD_ADD, 32'hFFFF_FFFF);
        push_item(wma_pkg::CMD_ADD, 32'hFFFF_0000);
        push_item(wma_pkg::CMD_ADD, 32'hFFFE_FFFF);
        push_item(wma_pkg::CMD_CLEAR, 32'hFFFF_FFFF);
        push_item(wma_pkg::CMD_ADD, 32'h0001_0000);
        push_item(wma_pkg::CMD_ADD, 32'h8000_0000);

        // single slot: clamped sum builds up until the average saturates
        write_length(9'd1);
        push_item(wma_pkg::CMD_ADD, 32'h7FFF_FFFF);
        push_item(wma_pkg::CMD_ADD, 32'h8000_0000);
        push_item(wma_pkg::CMD_ADD, 32'h7FFF_FFFF);
        push_item(wma_pkg::CMD_ADD, 32'h8000_0000);
        push_item(wma_pkg::CMD_ADD, 32'h5555_5555);
        push_item(wma_pkg::CMD_ADD, 32'hAAAA_AAAA);
        push_item(wma_pkg::CMD_CLEAR, '0);

        // zero length acts as one, oversize acts as the full store
        write_length(9'd0);
        push_item(wma_pkg::CMD_ADD, 32'h1234_5678);
        push_item(wma_pkg::CMD_ADD, 32'hEDCB_A987);
        write_length(9'd511);
        push_item(wma_pkg::CMD_ADD, 32'h7FFF_FFFF);
        push_item(wma_pkg::CMD_ADD, 32'h0000_0001);
        push_item(wma_pkg::CMD_ADD, 32'h0000_0002);
        push_item(wma_pkg::CMD_ADD, 32'h0000_0003);

        // shrink below the write position: next add wraps
        write_length(9'd2);
        push_item(wma_pkg::CMD_ADD, 32'h0002_0000);
        push_item(wma_pkg::CMD_ADD, 32'hFFFF_8000);

        while (items_sent < ITEM_TARGET) begin
            next_length = ($urandom_range(0, 4) == 0) ? 9'($urandom_range(1, 300))
                                                      : lengths[$urandom_range(0, 13)];
            write_length(next_length);
            phase_items = $urandom_range(30, 120);
            repeat (phase_items)
                push_item(($urandom_range(0, 24) == 0) ? wma_pkg::CMD_CLEAR : wma_pkg::CMD_ADD,
                          pick_sample());
        end

        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        // leave room for any stray result
        repeat (400) @(posedge i_clk);
        if (errors == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
